// ===== design/dtq_pkg.sv =====
`timescale 1ns / 1ps

package dtq_pkg;

  // Sizes
  localparam int NUM_IDS         = 32;
  localparam int ID_W            = 5;
  localparam int TIME_W          = 48;
  localparam int IV_W            = 40;
  localparam int MIN_DLY_W       = 20;
  localparam int CAPACITY        = 32;
  localparam int MIN_DELAY_RESET = 100;
  localparam int SCAN_W          = $clog2(NUM_IDS + 1);
  localparam int CNT_W           = $clog2(NUM_IDS + 1);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_EXPIRE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ACTIVE = 2'd2;

  // One stored timer
  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [IV_W-1:0]   interval;
  } entry_t;

  // Shared adder request and response
  typedef struct packed {
    logic              sub;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              carry;
    logic [TIME_W-1:0] res;
  } alu_rsp_t;

endpackage

// ===== design/dtq_entry_ram.sv =====
`timescale 1ns / 1ps

module dtq_entry_ram import dtq_pkg::*; (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [ID_W-1:0] wr_addr,
  input  entry_t          wr_data,
  input  logic [ID_W-1:0] rd_addr,
  output entry_t          rd_data
);

  entry_t mem [NUM_IDS];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/dtq_alu.sv =====
`timescale 1ns / 1ps

module dtq_alu import dtq_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [TIME_W-1:0] b_op;
  logic [TIME_W:0]   sum;

  // a - b (carry set when a >= b) or saturating a + b
  always_comb begin
    b_op      = req.sub ? ~req.b : req.b;
    sum       = {1'b0, req.a} + {1'b0, b_op} + (TIME_W + 1)'(req.sub);
    rsp.carry = sum[TIME_W];
    rsp.res   = (!req.sub && sum[TIME_W]) ? TIME_MAX : sum[TIME_W-1:0];
  end

endmodule

// ===== design/deadline_timer_queue.sv =====
`timescale 1ns / 1ps

// Ordered timer queue with periodic re-arm, 32 timer ids.
// Input channel (in_valid/in_ready) carries one command item: add, cancel
// or expire at now_time. Output channel (out_valid/out_ready) returns the
// result items; last marks the final result of a command. A config channel
// (cfg_valid/cfg_ready, always ready) writes min_delay_us; the user must
// do so only while idle, the block does not enforce it. One command at a
// time; in_ready is high only in the idle state. Every table walk reads
// the entry memory one id per cycle. Cancel or an unknown command needs no
// walk; add takes one walk for the earliest active expiry; expire takes a
// mark walk, one ordering walk per fired timer plus one, and a final
// earliest walk.
// The result sits in an output register; a new command is taken while it
// waits, and a stalled receiver simply holds the sequencer at its next
// result. Reset clears all active bits, the output valid and restores
// min_delay_us to 100; expiry and interval storage needs no clearing.
module deadline_timer_queue import dtq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           command,
  input  logic [ID_W-1:0]      timer_id,
  input  logic [TIME_W-1:0]    expiry_time,
  input  logic [IV_W-1:0]      interval_us,
  input  logic [TIME_W-1:0]    now_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 fired_valid,
  output logic [ID_W-1:0]      fired_id,
  output logic                 rearm,
  output logic [TIME_W-1:0]    next_delay_us,
  output logic [1:0]           status,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [MIN_DLY_W-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_ONE    = 4'd2;
  localparam logic [3:0] S_ESCAN  = 4'd3;
  localparam logic [3:0] S_ADD1   = 4'd4;
  localparam logic [3:0] S_ADD2   = 4'd5;
  localparam logic [3:0] S_MARK   = 4'd6;
  localparam logic [3:0] S_DSCAN  = 4'd7;
  localparam logic [3:0] S_FIRE   = 4'd8;
  localparam logic [3:0] S_XFIN   = 4'd9;

  logic [3:0]           state;
  logic [1:0]           cmd_q;
  logic [ID_W-1:0]      id_q;
  logic [TIME_W-1:0]    exp_q;
  logic [IV_W-1:0]      iv_q;
  logic [TIME_W-1:0]    now_q;
  logic [MIN_DLY_W-1:0] min_delay;
  logic [NUM_IDS-1:0]   active;
  logic [NUM_IDS-1:0]   due;
  logic [CNT_W-1:0]     count;
  logic [SCAN_W-1:0]    scan_cnt;
  logic                 proc_vld;
  logic [ID_W-1:0]      proc_idx;
  logic                 best_found;
  logic [TIME_W-1:0]    best_exp;
  logic [ID_W-1:0]      best_id;
  logic [IV_W-1:0]      best_iv;
  logic                 pend_fv;
  logic [ID_W-1:0]      pend_id;
  logic [1:0]           pend_status;
  logic                 rearm_q;

  logic                 scan_state;
  logic                 scan_issue;
  logic                 scan_done;
  logic                 out_free;
  logic                 fire_go;
  logic                 lt;
  logic                 full;
  logic [TIME_W-1:0]    d_raw;
  logic [TIME_W-1:0]    min_ext;
  logic [TIME_W-1:0]    dly;

  logic                 wr_en;
  logic [ID_W-1:0]      wr_addr;
  entry_t               wr_data;
  entry_t               rd_data;
  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;

  dtq_entry_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (scan_cnt[ID_W-1:0]),
    .rd_data (rd_data)
  );

  dtq_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Table walk control
  assign scan_state = (state == S_MARK) || (state == S_DSCAN) || (state == S_ESCAN);
  assign scan_issue = scan_state && (scan_cnt != SCAN_W'(NUM_IDS));
  assign scan_done  = (scan_cnt == SCAN_W'(NUM_IDS)) && !proc_vld;
  assign out_free   = !out_valid || out_ready;
  assign fire_go    = !pend_fv || out_free;
  assign full       = int'(count) >= CAPACITY;

  // Shared adder operand select
  always_comb begin
    alu_req.sub = 1'b1;
    alu_req.a   = rd_data.expiry;
    alu_req.b   = best_exp;
    case (state)
      S_MARK: begin
        alu_req.a = now_q;
        alu_req.b = rd_data.expiry;
      end
      S_ADD1: begin
        alu_req.a = exp_q;
        alu_req.b = best_exp;
      end
      S_ADD2: begin
        alu_req.a = exp_q;
        alu_req.b = now_q;
      end
      S_FIRE: begin
        alu_req.sub = 1'b0;
        alu_req.a   = now_q;
        alu_req.b   = TIME_W'(best_iv);
      end
      S_XFIN: begin
        alu_req.a = best_exp;
        alu_req.b = now_q;
      end
      default: begin
        alu_req.sub = 1'b1;
      end
    endcase
  end

  assign lt = !alu_rsp.carry;

  // Delay to deadline, floored at min_delay
  always_comb begin
    d_raw   = alu_rsp.carry ? alu_rsp.res : '0;
    min_ext = TIME_W'(min_delay);
    dly     = (d_raw < min_ext) ? min_ext : d_raw;
  end

  // Entry memory write: new timer or re-arm
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_id;
    wr_data = '{expiry: alu_rsp.res, interval: best_iv};
    if (state == S_ADD1) begin
      wr_en   = 1'b1;
      wr_addr = id_q;
      wr_data = '{expiry: exp_q, interval: iv_q};
    end else if (state == S_FIRE && fire_go && best_iv != '0) begin
      wr_en = 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      min_delay  <= MIN_DLY_W'(MIN_DELAY_RESET);
      active     <= '0;
      due        <= '0;
      count      <= '0;
      scan_cnt   <= '0;
      proc_vld   <= 1'b0;
      best_found <= 1'b0;
      pend_fv    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        min_delay <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // walk pipeline: address out, data back next cycle
      if (scan_state) begin
        if (scan_issue) begin
          scan_cnt <= scan_cnt + SCAN_W'(1);
          proc_vld <= 1'b1;
          proc_idx <= scan_cnt[ID_W-1:0];
        end else begin
          proc_vld <= 1'b0;
        end
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q <= command;
            id_q  <= timer_id;
            exp_q <= expiry_time;
            iv_q  <= interval_us;
            now_q <= now_time;
            state <= S_DECODE;
          end
        end

        S_DECODE: begin
          case (cmd_q)
            CMD_ADD: begin
              if (active[id_q]) begin
                pend_status <= ST_ACTIVE;
                state       <= S_ONE;
              end else if (full) begin
                pend_status <= ST_FULL;
                state       <= S_ONE;
              end else begin
                scan_cnt   <= '0;
                proc_vld   <= 1'b0;
                best_found <= 1'b0;
                state      <= S_ESCAN;
              end
            end
            CMD_CANCEL: begin
              if (active[id_q]) begin
                active[id_q] <= 1'b0;
                count        <= count - CNT_W'(1);
              end
              pend_status <= ST_OK;
              state       <= S_ONE;
            end
            CMD_EXPIRE: begin
              scan_cnt <= '0;
              proc_vld <= 1'b0;
              due      <= '0;
              pend_fv  <= 1'b0;
              pend_id  <= '0;
              state    <= S_MARK;
            end
            default: begin
              pend_status <= ST_OK;
              state       <= S_ONE;
            end
          endcase
        end

        // single result with only a status
        S_ONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            fired_valid   <= 1'b0;
            fired_id      <= '0;
            rearm         <= 1'b0;
            next_delay_us <= '0;
            status        <= pend_status;
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end

        // earliest active expiry; ascending walk keeps lowest id on ties
        S_ESCAN: begin
          if (proc_vld && active[proc_idx] && (!best_found || lt)) begin
            best_found <= 1'b1;
            best_exp   <= rd_data.expiry;
          end
          if (scan_done) begin
            state <= (cmd_q == CMD_ADD) ? S_ADD1 : S_XFIN;
          end
        end

        S_ADD1: begin
          rearm_q      <= !best_found || lt;
          active[id_q] <= 1'b1;
          count        <= count + CNT_W'(1);
          state        <= S_ADD2;
        end

        S_ADD2: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            fired_valid   <= 1'b0;
            fired_id      <= '0;
            rearm         <= rearm_q;
            next_delay_us <= rearm_q ? dly : '0;
            status        <= ST_OK;
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end

        // mark due timers and take them out of the active set
        S_MARK: begin
          if (proc_vld && active[proc_idx] && alu_rsp.carry) begin
            due[proc_idx]    <= 1'b1;
            active[proc_idx] <= 1'b0;
            count            <= count - CNT_W'(1);
          end
          if (scan_done) begin
            scan_cnt   <= '0;
            proc_vld   <= 1'b0;
            best_found <= 1'b0;
            state      <= S_DSCAN;
          end
        end

        // pick the smallest (expiry, id) among due timers
        S_DSCAN: begin
          if (proc_vld && due[proc_idx] && (!best_found || lt)) begin
            best_found <= 1'b1;
            best_exp   <= rd_data.expiry;
            best_id    <= proc_idx;
            best_iv    <= rd_data.interval;
          end
          if (scan_done) begin
            scan_cnt   <= '0;
            proc_vld   <= 1'b0;
            best_found <= 1'b0;
            if (best_found) begin
              state <= S_FIRE;
            end else begin
              state <= S_ESCAN;
            end
          end
        end

        // emit the previous fire, hold this one until its successor is known
        S_FIRE: begin
          if (fire_go) begin
            if (pend_fv) begin
              out_valid     <= 1'b1;
              fired_valid   <= 1'b1;
              fired_id      <= pend_id;
              rearm         <= 1'b0;
              next_delay_us <= '0;
              status        <= ST_OK;
              last          <= 1'b0;
            end
            due[best_id] <= 1'b0;
            if (best_iv != '0) begin
              active[best_id] <= 1'b1;
              count           <= count + CNT_W'(1);
            end
            pend_fv    <= 1'b1;
            pend_id    <= best_id;
            scan_cnt   <= '0;
            proc_vld   <= 1'b0;
            best_found <= 1'b0;
            state      <= S_DSCAN;
          end
        end

        // final expire result with the delay to the new earliest timer
        S_XFIN: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            fired_valid   <= pend_fv;
            fired_id      <= pend_id;
            rearm         <= best_found;
            next_delay_us <= best_found ? dly : '0;
            status        <= ST_OK;
            last          <= 1'b1;
            pend_fv       <= 1'b0;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
